FILE: hdl/pop3sb_pkg.sv
// Shared types and constants for the POP3 STLS banner parser.
// Phase codes, action codes and the per-byte result record.
// No dependencies.
package pop3sb_pkg;

	typedef enum logic [16:0] {
		PH_G0      = 17'h00001,
		PH_G1      = 17'h00002,
		PH_G2      = 17'h00004,
		PH_GLINE   = 17'h00008,
		PH_C0      = 17'h00010,
		PH_C1      = 17'h00020,
		PH_C2      = 17'h00040,
		PH_CLINE   = 17'h00080,
		PH_CBOL    = 17'h00100,
		PH_CDOT    = 17'h00200,
		PH_S0      = 17'h00400,
		PH_S1      = 17'h00800,
		PH_S2      = 17'h01000,
		PH_SLINE   = 17'h02000,
		PH_NEGLINE = 17'h04000,
		PH_CLOSED  = 17'h08000,
		PH_HANDED  = 17'h10000
	} phase_t;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_CAPA  = 3'd1,
		ACT_STLS  = 3'd2,
		ACT_CLOSE = 3'd3,
		ACT_TLS   = 3'd4
	} action_t;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef struct packed {
		logic       stopped;
		action_t    action;
		logic       banner_valid;
		logic [7:0] banner_byte;
	} result_t;

endpackage

FILE: hdl/pop3sb_step.sv
// Next-phase and result logic for one received byte.
// Uses pop3sb_pkg for phase, action and result types.
module pop3sb_step (
	input  pop3sb_pkg::phase_t  phase,
	input  logic [7:0]          rx_byte,
	input  logic                new_session,
	output pop3sb_pkg::phase_t  phase_nxt,
	output pop3sb_pkg::result_t res
);

	pop3sb_pkg::phase_t ph;
	logic               run;
	logic               echo;

	always_comb begin
		ph        = new_session ? pop3sb_pkg::PH_G0 : phase;
		run       = (ph != pop3sb_pkg::PH_CLOSED) && (ph != pop3sb_pkg::PH_HANDED);
		echo      = run && (rx_byte != pop3sb_pkg::CH_CR);
		phase_nxt = ph;
		res.stopped      = !run;
		res.action       = pop3sb_pkg::ACT_NONE;
		res.banner_valid = echo;
		res.banner_byte  = echo ? rx_byte : 8'h00;
		if (echo) begin
			case (ph)
				pop3sb_pkg::PH_G0: begin
					if (rx_byte == pop3sb_pkg::CH_PLUS) phase_nxt = pop3sb_pkg::PH_G1;
					else begin
						phase_nxt  = pop3sb_pkg::PH_CLOSED;
						res.action = pop3sb_pkg::ACT_CLOSE;
					end
				end
				pop3sb_pkg::PH_G1: begin
					if (rx_byte == pop3sb_pkg::CH_O) phase_nxt = pop3sb_pkg::PH_G2;
					else begin
						phase_nxt  = pop3sb_pkg::PH_CLOSED;
						res.action = pop3sb_pkg::ACT_CLOSE;
					end
				end
				pop3sb_pkg::PH_G2: begin
					if (rx_byte == pop3sb_pkg::CH_K) phase_nxt = pop3sb_pkg::PH_GLINE;
					else begin
						phase_nxt  = pop3sb_pkg::PH_CLOSED;
						res.action = pop3sb_pkg::ACT_CLOSE;
					end
				end
				pop3sb_pkg::PH_GLINE: begin
					if (rx_byte == pop3sb_pkg::CH_LF) begin
						phase_nxt  = pop3sb_pkg::PH_C0;
						res.action = pop3sb_pkg::ACT_CAPA;
					end
				end
				pop3sb_pkg::PH_C0, pop3sb_pkg::PH_S0: begin
					if (rx_byte == pop3sb_pkg::CH_MINUS) phase_nxt = pop3sb_pkg::PH_NEGLINE;
					else if (rx_byte == pop3sb_pkg::CH_PLUS)
						phase_nxt = (ph == pop3sb_pkg::PH_C0) ? pop3sb_pkg::PH_C1
							: pop3sb_pkg::PH_S1;
					else begin
						phase_nxt  = pop3sb_pkg::PH_CLOSED;
						res.action = pop3sb_pkg::ACT_CLOSE;
					end
				end
				pop3sb_pkg::PH_C1, pop3sb_pkg::PH_S1: begin
					if (rx_byte == pop3sb_pkg::CH_O)
						phase_nxt = (ph == pop3sb_pkg::PH_C1) ? pop3sb_pkg::PH_C2
							: pop3sb_pkg::PH_S2;
					else begin
						phase_nxt  = pop3sb_pkg::PH_CLOSED;
						res.action = pop3sb_pkg::ACT_CLOSE;
					end
				end
				pop3sb_pkg::PH_C2, pop3sb_pkg::PH_S2: begin
					if (rx_byte == pop3sb_pkg::CH_K)
						phase_nxt = (ph == pop3sb_pkg::PH_C2) ? pop3sb_pkg::PH_CLINE
							: pop3sb_pkg::PH_SLINE;
					else begin
						phase_nxt  = pop3sb_pkg::PH_CLOSED;
						res.action = pop3sb_pkg::ACT_CLOSE;
					end
				end
				pop3sb_pkg::PH_CLINE: begin
					if (rx_byte == pop3sb_pkg::CH_LF) phase_nxt = pop3sb_pkg::PH_CBOL;
				end
				pop3sb_pkg::PH_CBOL: begin
					if (rx_byte == pop3sb_pkg::CH_DOT) phase_nxt = pop3sb_pkg::PH_CDOT;
					else if (rx_byte != pop3sb_pkg::CH_LF) phase_nxt = pop3sb_pkg::PH_CLINE;
				end
				pop3sb_pkg::PH_CDOT: begin
					if (rx_byte == pop3sb_pkg::CH_LF) begin
						phase_nxt  = pop3sb_pkg::PH_S0;
						res.action = pop3sb_pkg::ACT_STLS;
					end else
						phase_nxt = pop3sb_pkg::PH_CLINE;
				end
				pop3sb_pkg::PH_SLINE: begin
					if (rx_byte == pop3sb_pkg::CH_LF) begin
						phase_nxt  = pop3sb_pkg::PH_HANDED;
						res.action = pop3sb_pkg::ACT_TLS;
					end
				end
				pop3sb_pkg::PH_NEGLINE: begin
					if (rx_byte == pop3sb_pkg::CH_LF) begin
						phase_nxt  = pop3sb_pkg::PH_CLOSED;
						res.action = pop3sb_pkg::ACT_CLOSE;
					end
				end
				default: begin
					phase_nxt = ph;
				end
			endcase
		end
	end

endmodule

FILE: hdl/pop3_stls_banner_parser.sv
// Top level of the POP3 STLS banner parser: input register, phase
// register and result register around pop3sb_step. Uses pop3sb_pkg.
//
//  channel | dir | tdata           | tuser
//  s_      | in  | [7:0] rx_byte   | [0] new_session
//  m_      | out | [7:0] banner_byte | [0] banner_valid, [3:1] action, [4] stopped
//
// One byte per cycle sustained while m_ is ready; an s_ request reaches m_ through the
// input register, then the result register. The phase register is the only loop.
// arst_n clears the valid flags and sets the phase to the greeting start.
// A stall on m_ holds the result register; s_tready drops only once the input
// register is full as well.
module pop3_stls_banner_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] rx_byte
	input  logic       s_tuser,  // [0] new_session
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] banner_byte
	output logic [4:0] m_tuser   // [0] banner_valid, [3:1] action, [4] stopped
);

	logic                vld_s1;
	logic [7:0]          byte_s1;
	logic                news_s1;
	logic                vld_s2;
	pop3sb_pkg::result_t res_s2;
	pop3sb_pkg::phase_t  phase_q;
	pop3sb_pkg::phase_t  phase_nxt;
	pop3sb_pkg::result_t res;
	logic                adv_s2;
	logic                adv_s1;

	assign adv_s2   = !vld_s2 || m_tready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign s_tready = adv_s1;

	pop3sb_step u_step (
		.phase       (phase_q),
		.rx_byte     (byte_s1),
		.new_session (news_s1),
		.phase_nxt   (phase_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			phase_q <= pop3sb_pkg::PH_G0;
		end else begin
			if (adv_s1) vld_s1 <= s_tvalid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (vld_s1 && adv_s2) phase_q <= phase_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			byte_s1 <= s_tdata;
			news_s1 <= s_tuser;
		end
		if (adv_s2 && vld_s1) res_s2 <= res;
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = res_s2.banner_byte;
	assign m_tuser  = {res_s2.stopped, res_s2.action, res_s2.banner_valid};

`ifndef ASSERT_OFF
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase register not one-hot");

	a_stopped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4] |-> !m_tuser[0] && m_tuser[3:1] == pop3sb_pkg::ACT_NONE)
		else $error("stopped result carries echo or action");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv_s2 |=> vld_s1 && $stable(byte_s1) && $stable(news_s1))
		else $error("input register lost a request under stall");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s1 && adv_s2) |=> $stable(phase_q))
		else $error("phase moved without a byte passing");
`endif

endmodule

FILE: tb/tb_pop3_stls_banner_parser.sv
// Self-checking testbench for pop3_stls_banner_parser: a directed table, then random
// POP3 sessions; typed rows are checked against the table, all others against a phase tracker kept here.
// Depends on pop3sb_pkg and the parser RTL only.
module tb_pop3_stls_banner_parser;

	typedef struct packed {
		logic [7:0]          rx;
		logic                ns;
		logic                typed;
		pop3sb_pkg::result_t want;
	} dir_row_t;

	localparam pop3sb_pkg::result_t ANY = '{1'b0, pop3sb_pkg::ACT_NONE, 1'b0, 8'h00};
	localparam int N_DIR = 26;
	localparam dir_row_t DIRECTED [N_DIR] = '{
		'{8'h00, 1'b0, 1'b1, '{1'b0, pop3sb_pkg::ACT_CLOSE, 1'b1, 8'h00}},
		'{8'hFF, 1'b0, 1'b1, '{1'b1, pop3sb_pkg::ACT_NONE, 1'b0, 8'h00}},
		'{pop3sb_pkg::CH_CR, 1'b0, 1'b1, '{1'b1, pop3sb_pkg::ACT_NONE, 1'b0, 8'h00}},
		'{pop3sb_pkg::CH_PLUS, 1'b1, 1'b0, ANY},
		'{pop3sb_pkg::CH_O, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_K, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_CR, 1'b0, 1'b1, '{1'b0, pop3sb_pkg::ACT_NONE, 1'b0, 8'h00}},
		'{pop3sb_pkg::CH_LF, 1'b0, 1'b1,
			'{1'b0, pop3sb_pkg::ACT_CAPA, 1'b1, pop3sb_pkg::CH_LF}},
		'{pop3sb_pkg::CH_MINUS, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_LF, 1'b0, 1'b1,
			'{1'b0, pop3sb_pkg::ACT_CLOSE, 1'b1, pop3sb_pkg::CH_LF}},
		'{pop3sb_pkg::CH_PLUS, 1'b1, 1'b0, ANY},
		'{pop3sb_pkg::CH_O, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_K, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_LF, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_PLUS, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_O, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_K, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_LF, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_LF, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_DOT, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_LF, 1'b0, 1'b1,
			'{1'b0, pop3sb_pkg::ACT_STLS, 1'b1, pop3sb_pkg::CH_LF}},
		'{pop3sb_pkg::CH_PLUS, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_O, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_K, 1'b0, 1'b0, ANY},
		'{pop3sb_pkg::CH_LF, 1'b0, 1'b1,
			'{1'b0, pop3sb_pkg::ACT_TLS, 1'b1, pop3sb_pkg::CH_LF}},
		'{8'h80, 1'b0, 1'b1, '{1'b1, pop3sb_pkg::ACT_NONE, 1'b0, 8'h00}}
	};

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [4:0] m_tuser;

	pop3sb_pkg::result_t results_due[$];
	pop3sb_pkg::phase_t  track_phase;
	pop3sb_pkg::phase_t  plan_phase;
	logic [7:0]          plan_bytes[$];
	logic                plan_ns[$];
	int                  plan_live;
	int                  send_idle_pct;
	int                  recv_idle_pct;
	int                  mismatches;
	int                  results_checked;
	int                  bytes_fed;
	int                  sessions;
	int                  act_count[5];

	pop3_stls_banner_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic pop3sb_pkg::result_t parse_byte(input pop3sb_pkg::phase_t ph_in,
		input logic [7:0] c, input logic ns, output pop3sb_pkg::phase_t ph_out);
		pop3sb_pkg::result_t r;
		pop3sb_pkg::phase_t  ph;
		logic                fail;
		ph = ns ? pop3sb_pkg::PH_G0 : ph_in;
		ph_out = ph;
		fail = 1'b0;
		r = '{1'b0, pop3sb_pkg::ACT_NONE, 1'b0, 8'h00};
		if (ph == pop3sb_pkg::PH_CLOSED || ph == pop3sb_pkg::PH_HANDED) begin
			r.stopped = 1'b1;
		end else if (c != pop3sb_pkg::CH_CR) begin
			r.banner_valid = 1'b1;
			r.banner_byte = c;
			case (ph)
				pop3sb_pkg::PH_G0: begin
					if (c == pop3sb_pkg::CH_PLUS) ph_out = pop3sb_pkg::PH_G1;
					else fail = 1'b1;
				end
				pop3sb_pkg::PH_G1: begin
					if (c == pop3sb_pkg::CH_O) ph_out = pop3sb_pkg::PH_G2;
					else fail = 1'b1;
				end
				pop3sb_pkg::PH_G2: begin
					if (c == pop3sb_pkg::CH_K) ph_out = pop3sb_pkg::PH_GLINE;
					else fail = 1'b1;
				end
				pop3sb_pkg::PH_GLINE: begin
					if (c == pop3sb_pkg::CH_LF) begin
						ph_out = pop3sb_pkg::PH_C0;
						r.action = pop3sb_pkg::ACT_CAPA;
					end
				end
				pop3sb_pkg::PH_C0: begin
					if (c == pop3sb_pkg::CH_MINUS) ph_out = pop3sb_pkg::PH_NEGLINE;
					else if (c == pop3sb_pkg::CH_PLUS) ph_out = pop3sb_pkg::PH_C1;
					else fail = 1'b1;
				end
				pop3sb_pkg::PH_C1: begin
					if (c == pop3sb_pkg::CH_O) ph_out = pop3sb_pkg::PH_C2;
					else fail = 1'b1;
				end
				pop3sb_pkg::PH_C2: begin
					if (c == pop3sb_pkg::CH_K) ph_out = pop3sb_pkg::PH_CLINE;
					else fail = 1'b1;
				end
				pop3sb_pkg::PH_CLINE: begin
					if (c == pop3sb_pkg::CH_LF) ph_out = pop3sb_pkg::PH_CBOL;
				end
				pop3sb_pkg::PH_CBOL: begin
					if (c == pop3sb_pkg::CH_DOT) ph_out = pop3sb_pkg::PH_CDOT;
					else if (c != pop3sb_pkg::CH_LF) ph_out = pop3sb_pkg::PH_CLINE;
				end
				pop3sb_pkg::PH_CDOT: begin
					if (c == pop3sb_pkg::CH_LF) begin
						ph_out = pop3sb_pkg::PH_S0;
						r.action = pop3sb_pkg::ACT_STLS;
					end else ph_out = pop3sb_pkg::PH_CLINE;
				end
				pop3sb_pkg::PH_S0: begin
					if (c == pop3sb_pkg::CH_MINUS) ph_out = pop3sb_pkg::PH_NEGLINE;
					else if (c == pop3sb_pkg::CH_PLUS) ph_out = pop3sb_pkg::PH_S1;
					else fail = 1'b1;
				end
				pop3sb_pkg::PH_S1: begin
					if (c == pop3sb_pkg::CH_O) ph_out = pop3sb_pkg::PH_S2;
					else fail = 1'b1;
				end
				pop3sb_pkg::PH_S2: begin
					if (c == pop3sb_pkg::CH_K) ph_out = pop3sb_pkg::PH_SLINE;
					else fail = 1'b1;
				end
				pop3sb_pkg::PH_SLINE: begin
					if (c == pop3sb_pkg::CH_LF) begin
						ph_out = pop3sb_pkg::PH_HANDED;
						r.action = pop3sb_pkg::ACT_TLS;
					end
				end
				pop3sb_pkg::PH_NEGLINE: begin
					if (c == pop3sb_pkg::CH_LF) fail = 1'b1;
				end
				default: begin
					r = '{1'b1, pop3sb_pkg::ACT_NONE, 1'b0, 8'h00};
				end
			endcase
			if (fail) begin
				ph_out = pop3sb_pkg::PH_CLOSED;
				r.action = pop3sb_pkg::ACT_CLOSE;
			end
		end
		return r;
	endfunction

	task automatic feed_byte(input logic [7:0] c, input logic ns, input logic typed,
		input pop3sb_pkg::result_t want);
		pop3sb_pkg::result_t r;
		pop3sb_pkg::phase_t  nxt;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= ns;
		do @(posedge clk); while (!s_tready);
		r = parse_byte(track_phase, c, ns, nxt);
		track_phase = nxt;
		if (typed)
			r = want;
		act_count[int'(r.action)]++;
		bytes_fed++;
		results_due.push_back(r);
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic plan(input logic [7:0] c, input logic ns);
		pop3sb_pkg::result_t r;
		pop3sb_pkg::phase_t  nxt;
		logic [7:0]          b;
		b = ($urandom_range(99) < 2) ? 8'($urandom_range(255)) : c;
		r = parse_byte(plan_phase, b, ns, nxt);
		plan_phase = nxt;
		if (!r.stopped)
			plan_live++;
		plan_bytes.push_back(b);
		plan_ns.push_back(ns);
	endtask

	task automatic plan_text;
		int n;
		logic [7:0] b;
		n = $urandom_range(10);
		repeat (n) begin
			if ($urandom_range(7) == 0)
				b = 8'($urandom_range(255));
			else
				b = 8'($urandom_range(8'h7E, 8'h20));
			if (b == pop3sb_pkg::CH_LF)
				b = 8'h20;
			plan(b, 1'b0);
		end
	endtask

	task automatic plan_eol;
		if ($urandom_range(1))
			plan(pop3sb_pkg::CH_CR, 1'b0);
		plan(pop3sb_pkg::CH_LF, 1'b0);
	endtask

	task automatic plan_ok;
		plan(pop3sb_pkg::CH_PLUS, 1'b0);
		plan(pop3sb_pkg::CH_O, 1'b0);
		plan(pop3sb_pkg::CH_K, 1'b0);
	endtask

	task automatic plan_session;
		int n;
		sessions++;
		if ($urandom_range(99) < 8) begin
			n = $urandom_range(12, 1);
			repeat (n)
				plan(8'($urandom_range(255)), 1'($urandom_range(1)));
			return;
		end
		plan(pop3sb_pkg::CH_PLUS, 1'b1);
		plan(pop3sb_pkg::CH_O, 1'b0);
		plan(pop3sb_pkg::CH_K, 1'b0);
		plan_text();
		plan_eol();
		if ($urandom_range(99) < 10) begin
			plan(pop3sb_pkg::CH_MINUS, 1'b0);
			plan_text();
			plan_eol();
		end else begin
			plan_ok();
			plan_text();
			plan_eol();
			n = $urandom_range(4);
			repeat (n) begin
				case ($urandom_range(2))
					0: plan_eol();
					1: begin
						plan(pop3sb_pkg::CH_DOT, 1'b0);
						plan(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
						plan_text();
						plan_eol();
					end
					default: begin
						plan_text();
						plan_eol();
					end
				endcase
			end
			plan(pop3sb_pkg::CH_DOT, 1'b0);
			plan_eol();
			if ($urandom_range(99) < 10)
				plan(pop3sb_pkg::CH_MINUS, 1'b0);
			else
				plan_ok();
			plan_text();
			plan_eol();
		end
		n = $urandom_range(3);
		repeat (n)
			plan(8'($urandom_range(255)), 1'b0);
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		pop3sb_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: data=%02h user=%05b", m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				results_checked++;
				if (m_tuser[0] !== want.banner_valid || m_tdata !== want.banner_byte ||
					m_tuser[3:1] !== want.action || m_tuser[4] !== want.stopped) begin
					if (mismatches < 10) begin
						$display("mismatch on result %0d: want valid=%0b byte=%02h act=%0d stop=%0b",
							results_checked, want.banner_valid, want.banner_byte,
							want.action, want.stopped);
						$display("  got valid=%0b byte=%02h act=%0d stop=%0b",
							m_tuser[0], m_tdata, m_tuser[3:1], m_tuser[4]);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int rnd_phase;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		send_idle_pct = 15;
		recv_idle_pct = 64;
		mismatches = 0;
		results_checked = 0;
		bytes_fed = 0;
		sessions = 0;
		foreach (act_count[i])
			act_count[i] = 0;
		track_phase = pop3sb_pkg::PH_G0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIR; i++)
			feed_byte(DIRECTED[i].rx, DIRECTED[i].ns, DIRECTED[i].typed,
				DIRECTED[i].want);
		drain();

		for (rnd_phase = 0; rnd_phase < 3; rnd_phase++) begin
			send_idle_pct = (rnd_phase == 0) ? 15 : (rnd_phase == 1) ? 64 : 0;
			recv_idle_pct = (rnd_phase == 0) ? 64 : (rnd_phase == 1) ? 15 : 0;
			plan_phase = track_phase;
			plan_live = 0;
			while (plan_live < 460)
				plan_session();
			while (plan_bytes.size() != 0)
				feed_byte(plan_bytes.pop_front(), plan_ns.pop_front(), 1'b0, ANY);
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Fed %0d bytes in %0d random sessions; checked %0d results.",
			bytes_fed, sessions, results_checked);
		$display("Actions seen: CAPA %0d, STLS %0d, close %0d, TLS hand-off %0d.",
			act_count[pop3sb_pkg::ACT_CAPA], act_count[pop3sb_pkg::ACT_STLS],
			act_count[pop3sb_pkg::ACT_CLOSE], act_count[pop3sb_pkg::ACT_TLS]);
		if (mismatches == 0 && results_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/pop3sb_pkg.sv
hdl/pop3sb_step.sv
hdl/pop3_stls_banner_parser.sv
tb/tb_pop3_stls_banner_parser.sv
